[src/dedup_inbox_with_tombstones_macros.svh]
// Assertion macros used by the block's top file.
`ifndef DEDUP_INBOX_WITH_TOMBSTONES_MACROS_SVH
`define DEDUP_INBOX_WITH_TOMBSTONES_MACROS_SVH
`ifndef SYNTHESIS
`define DIB_ASSERT_IMP(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("dib assertion failed");
`define DIB_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("dib assertion failed");
`else
`define DIB_ASSERT_IMP(label, clk, rst, cond, prop)
`define DIB_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

[src/dib_pkg.sv]
package dib_pkg;

  localparam int unsigned INBOX_DEPTH_DEF = 8;
  localparam int unsigned TEXT_LIMIT_DEF  = 256;
  localparam int unsigned TOMB_DEPTH_DEF  = 8;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [1:0] OP_BYTE   = 2'd0;
  localparam logic [1:0] OP_RM_IDX = 2'd1;
  localparam logic [1:0] OP_RM_ID  = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [2:0] OUT_REJECTED  = 3'd0;
  localparam logic [2:0] OUT_TOMB_HIT  = 3'd1;
  localparam logic [2:0] OUT_REFRESHED = 3'd2;
  localparam logic [2:0] OUT_INSERTED  = 3'd3;
  localparam logic [2:0] OUT_INS_EVICT = 3'd4;
  localparam logic [2:0] OUT_REMOVED   = 3'd5;
  localparam logic [2:0] OUT_NOT_FOUND = 3'd6;
  localparam logic [2:0] OUT_READ      = 3'd7;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  text_byte;
    logic        last_byte;
    logic        is_sync;
    logic [31:0] from_node;
    logic [31:0] rx_time;
    logic [7:0]  slot_index;
    logic [31:0] target_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic        accepted;
    logic [3:0]  entry_count;
    logic [31:0] change_seq;
    logic [31:0] entry_id;
    logic [31:0] entry_from;
    logic [31:0] entry_time;
  } out_item_t;

  typedef struct packed {
    logic       take;
    logic       ptr_clr;
    logic       ptr_inc;
    logic       ptr_load;
    logic       bidx_clr;
    logic       bidx_inc;
    logic       copy_wr;
    logic       refresh;
    logic       remove;
    logic       evict;
    logic       insert;
    logic       stg_clr;
    logic       res;
    logic [2:0] outcome;
  } cmd_t;

  typedef struct packed {
    logic reject;
    logic tomb_hit;
    logic tomb_last;
    logic scan_end;
    logic len_eq;
    logic byte_end;
    logic byte_neq;
    logic id_eq;
    logic id_zero;
    logic idx_ok;
    logic full;
  } sts_t;

endpackage

[src/dib_stream_if.sv]
interface dib_stream_if #(parameter type item_t = logic);
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/dib_ctrl.sv]
module dib_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic [1:0]    req_op,
  input  logic          req_last,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  input  dib_pkg::sts_t sts,
  output dib_pkg::cmd_t cmd
);
  import dib_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_JUDGE, S_TOMB, S_SCAN, S_CMP_RD, S_CMP_CHK, S_INS,
    S_COPY_RD, S_COPY_WR, S_RM_IDX, S_ID_SCAN, S_REMOVE, S_RESP
  } state_t;

  state_t     state, state_next;
  logic [2:0] outc, outc_next;
  logic       evicted, evicted_next;
  logic       rsp_valid_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    state_next   = state;
    outc_next    = outc;
    evicted_next = evicted;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.take    = 1'b1;
          cmd.ptr_clr = 1'b1;
          case (req_op)
            OP_BYTE:   if (req_last) state_next = S_JUDGE;
            OP_RM_IDX: state_next = S_RM_IDX;
            OP_RM_ID:  state_next = S_ID_SCAN;
            default: begin
              outc_next  = OUT_READ;
              state_next = S_RESP;
            end
          endcase
        end
      end
      S_JUDGE: begin
        if (sts.reject) begin
          outc_next   = OUT_REJECTED;
          cmd.stg_clr = 1'b1;
          state_next  = S_RESP;
        end else begin
          state_next = S_TOMB;
        end
      end
      S_TOMB: begin
        if (sts.tomb_hit) begin
          outc_next   = OUT_TOMB_HIT;
          cmd.stg_clr = 1'b1;
          state_next  = S_RESP;
        end else if (sts.tomb_last) begin
          cmd.ptr_clr = 1'b1;
          state_next  = S_SCAN;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_SCAN: begin
        if (sts.scan_end) begin
          state_next = S_INS;
        end else if (sts.len_eq) begin
          cmd.bidx_clr = 1'b1;
          state_next   = S_CMP_RD;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_CMP_RD: begin
        if (sts.byte_end) begin
          cmd.refresh = 1'b1;
          cmd.stg_clr = 1'b1;
          outc_next   = OUT_REFRESHED;
          state_next  = S_RESP;
        end else begin
          state_next = S_CMP_CHK;
        end
      end
      S_CMP_CHK: begin
        if (sts.byte_neq) begin
          cmd.ptr_inc = 1'b1;
          state_next  = S_SCAN;
        end else begin
          cmd.bidx_inc = 1'b1;
          state_next   = S_CMP_RD;
        end
      end
      S_INS: begin
        evicted_next = sts.full;
        cmd.evict    = sts.full;
        cmd.bidx_clr = 1'b1;
        state_next   = S_COPY_RD;
      end
      S_COPY_RD: begin
        if (sts.byte_end) begin
          cmd.insert  = 1'b1;
          cmd.stg_clr = 1'b1;
          outc_next   = evicted ? OUT_INS_EVICT : OUT_INSERTED;
          state_next  = S_RESP;
        end else begin
          state_next = S_COPY_WR;
        end
      end
      S_COPY_WR: begin
        cmd.copy_wr  = 1'b1;
        cmd.bidx_inc = 1'b1;
        state_next   = S_COPY_RD;
      end
      S_RM_IDX: begin
        if (sts.idx_ok) begin
          cmd.ptr_load = 1'b1;
          state_next   = S_REMOVE;
        end else begin
          outc_next  = OUT_NOT_FOUND;
          state_next = S_RESP;
        end
      end
      S_ID_SCAN: begin
        if (sts.id_zero || sts.scan_end) begin
          outc_next  = OUT_NOT_FOUND;
          state_next = S_RESP;
        end else if (sts.id_eq) begin
          state_next = S_REMOVE;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_REMOVE: begin
        cmd.remove = 1'b1;
        outc_next  = OUT_REMOVED;
        state_next = S_RESP;
      end
      S_RESP: begin
        // The output register may still hold the previous word.
        if (!rsp_valid || rsp_ready) begin
          cmd.res     = 1'b1;
          cmd.outcome = outc;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.res) rsp_valid_next = 1'b1;
    else if (rsp_ready) rsp_valid_next = 1'b0;
    else rsp_valid_next = rsp_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      outc      <= OUT_REJECTED;
      evicted   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      outc      <= outc_next;
      evicted   <= evicted_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

[src/dib_datapath.sv]
module dib_datapath #(
  parameter int unsigned INBOX_DEPTH = dib_pkg::INBOX_DEPTH_DEF,
  parameter int unsigned TEXT_LIMIT  = dib_pkg::TEXT_LIMIT_DEF,
  parameter int unsigned TOMB_DEPTH  = dib_pkg::TOMB_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  dib_pkg::in_item_t  in_data,
  input  dib_pkg::cmd_t      cmd,
  output dib_pkg::sts_t      sts,
  output dib_pkg::out_item_t out_data
);
  import dib_pkg::*;

  localparam int unsigned SW = (INBOX_DEPTH > 1) ? $clog2(INBOX_DEPTH) : 1;
  localparam int unsigned CW = $clog2(INBOX_DEPTH + 1);
  localparam int unsigned TW = (TOMB_DEPTH > 1) ? $clog2(TOMB_DEPTH) : 1;
  localparam int unsigned BW = $clog2(TEXT_LIMIT);
  localparam int unsigned LW = $clog2(TEXT_LIMIT + 1);
  localparam int unsigned PMAX = (INBOX_DEPTH > TOMB_DEPTH) ? INBOX_DEPTH : TOMB_DEPTH;
  localparam int unsigned PW = $clog2(PMAX + 1);
  localparam int unsigned MD = INBOX_DEPTH * (2 ** BW);

  // Entries live in fixed physical slots; slot_map gives the slot of each
  // position, so a removal or eviction shifts only the map.
  logic [SW-1:0] slot_map [INBOX_DEPTH];
  logic [LW-1:0] e_len    [INBOX_DEPTH];
  logic [31:0]   e_hash   [INBOX_DEPTH];
  logic [31:0]   e_from   [INBOX_DEPTH];
  logic [31:0]   e_time   [INBOX_DEPTH];
  logic [31:0]   e_id     [INBOX_DEPTH];
  logic [7:0]    text_mem [MD];
  logic [7:0]    stg_mem  [TEXT_LIMIT];
  logic [7:0]    text_q, stg_q;
  logic [31:0]   tomb     [TOMB_DEPTH];
  logic [TW-1:0] tpos;
  logic [CW-1:0] count;
  logic [31:0]   seq, next_id, last_id;
  logic [LW-1:0] stg_len;
  logic [31:0]   stg_hash;
  logic [PW-1:0] ptr;
  logic [LW-1:0] bidx;

  logic [1:0]    l_op;
  logic          l_sync;
  logic [31:0]   l_from, l_time, l_target;
  logic [7:0]    l_idx;

  logic [31:0]   hash_fix, id_inc;
  logic [SW-1:0] ptr_slot, free_slot, rd_slot, rm_pos;
  logic          shift_en, idx_ok, stage_wr;

  assign hash_fix  = (stg_hash == 32'd0) ? 32'd1 : stg_hash;
  assign ptr_slot  = slot_map[ptr[SW-1:0]];
  assign free_slot = slot_map[count[SW-1:0]];
  assign rd_slot   = slot_map[l_idx[SW-1:0]];
  assign rm_pos    = cmd.evict ? '0 : ptr[SW-1:0];
  assign shift_en  = cmd.remove || cmd.evict;
  assign idx_ok    = (16'(l_idx) < 16'(count));
  assign id_inc    = next_id + 32'd1;
  assign stage_wr  = cmd.take && (in_data.op == OP_BYTE) && (stg_len < LW'(TEXT_LIMIT));

  assign sts.reject    = !l_sync || (stg_len == LW'(TEXT_LIMIT));
  assign sts.tomb_hit  = (tomb[ptr[TW-1:0]] == hash_fix);
  assign sts.tomb_last = (ptr == PW'(TOMB_DEPTH - 1));
  assign sts.scan_end  = (ptr == PW'(count));
  assign sts.len_eq    = (e_len[ptr_slot] == stg_len);
  assign sts.byte_end  = (bidx == stg_len);
  assign sts.byte_neq  = (text_q != stg_q);
  assign sts.id_eq     = (e_id[ptr_slot] == l_target);
  assign sts.id_zero   = (l_target == 32'd0);
  assign sts.idx_ok    = idx_ok;
  assign sts.full      = (count == CW'(INBOX_DEPTH));

  // Text memories: one write and one registered read per cycle each.
  always_ff @(posedge clk) begin
    text_q <= text_mem[{ptr_slot, bidx[BW-1:0]}];
    stg_q  <= stg_mem[bidx[BW-1:0]];
    if (cmd.copy_wr) text_mem[{free_slot, bidx[BW-1:0]}] <= stg_q;
    if (stage_wr) stg_mem[stg_len[BW-1:0]] <= in_data.text_byte;
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      l_op     <= in_data.op;
      l_sync   <= in_data.is_sync;
      l_from   <= in_data.from_node;
      l_time   <= in_data.rx_time;
      l_target <= in_data.target_id;
      l_idx    <= in_data.slot_index;
    end
    if (cmd.refresh) begin
      e_from[ptr_slot] <= l_from;
      e_time[ptr_slot] <= l_time;
    end
    if (cmd.insert) begin
      e_len[free_slot]  <= stg_len;
      e_hash[free_slot] <= hash_fix;
      e_from[free_slot] <= l_from;
      e_time[free_slot] <= l_time;
      e_id[free_slot]   <= next_id;
      last_id           <= next_id;
    end
    if (cmd.res) begin
      out_data.outcome     <= cmd.outcome;
      out_data.accepted    <= (cmd.outcome == OUT_TOMB_HIT) ||
                              (cmd.outcome == OUT_REFRESHED) ||
                              (cmd.outcome == OUT_INSERTED) ||
                              (cmd.outcome == OUT_INS_EVICT) ||
                              ((cmd.outcome == OUT_REMOVED) && (l_op == OP_RM_ID));
      out_data.entry_count <= 4'(count);
      out_data.change_seq  <= seq;
      if ((cmd.outcome == OUT_INSERTED) || (cmd.outcome == OUT_INS_EVICT)) begin
        out_data.entry_id   <= last_id;
        out_data.entry_from <= 32'd0;
        out_data.entry_time <= 32'd0;
      end else if ((cmd.outcome == OUT_READ) && idx_ok) begin
        out_data.entry_id   <= e_id[rd_slot];
        out_data.entry_from <= e_from[rd_slot];
        out_data.entry_time <= e_time[rd_slot];
      end else begin
        out_data.entry_id   <= 32'd0;
        out_data.entry_from <= 32'd0;
        out_data.entry_time <= 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < INBOX_DEPTH; k++) slot_map[k] <= SW'(k);
      for (int k = 0; k < TOMB_DEPTH; k++) tomb[k] <= 32'd0;
      tpos     <= '0;
      count    <= '0;
      seq      <= 32'd0;
      next_id  <= 32'd1;
      stg_len  <= '0;
      stg_hash <= FNV_BASIS;
      ptr      <= '0;
      bidx     <= '0;
    end else begin
      if (cmd.take && (in_data.op == OP_BYTE)) begin
        stg_hash <= (stg_hash ^ {24'd0, in_data.text_byte}) * FNV_PRIME;
        if (stage_wr) stg_len <= stg_len + LW'(1);
      end
      if (cmd.stg_clr) begin
        stg_len  <= '0;
        stg_hash <= FNV_BASIS;
      end

      if (cmd.ptr_clr) ptr <= '0;
      else if (cmd.ptr_inc) ptr <= ptr + PW'(1);
      else if (cmd.ptr_load) ptr <= PW'(l_idx);

      if (cmd.bidx_clr) bidx <= '0;
      else if (cmd.bidx_inc) bidx <= bidx + LW'(1);

      // Close the gap at rm_pos and park its slot at the end of the map.
      if (shift_en) begin
        for (int k = 0; k < INBOX_DEPTH - 1; k++) begin
          if (k >= int'(rm_pos)) slot_map[k] <= slot_map[k + 1];
        end
        slot_map[INBOX_DEPTH - 1] <= slot_map[rm_pos];
        count <= count - CW'(1);
      end
      if (cmd.remove) begin
        tomb[tpos] <= e_hash[slot_map[rm_pos]];
        tpos <= (tpos == TW'(TOMB_DEPTH - 1)) ? '0 : tpos + TW'(1);
        seq  <= seq + 32'd1;
      end
      if (cmd.insert) begin
        count   <= count + CW'(1);
        seq     <= seq + 32'd1;
        next_id <= (id_inc == 32'd0) ? 32'd1 : id_inc;
      end
    end
  end

endmodule

[src/dedup_inbox_with_tombstones.sv]
// Deduplicating inbox for sync packets with a ring of recent tombstones.
// Channel req carries one word per step: a packet text byte, a removal by
// position or by id, or a read of an entry. Channel rsp returns one word for
// every step except a text byte that is not the last of its packet.
// A text byte that is not last is added to the staged packet and gives no
// word. The last byte is judged by a sequencer: a search of up to
// TOMB_DEPTH tombstones, then a scan of the parked entries with a byte-by-
// byte compare for entries of equal length, and on insert a byte-serial
// copy of the text into the entry memory. A removal by id searches the
// entries one by one.
// One item is in work at a time; req.ready is low until its word has been
// loaded into the output register. That register frees the sequencer, so the
// next item is taken while a word still waits on rsp; a second finished
// word waits inside the block until rsp.ready takes the first.
// Reset empties the inbox and the tombstone ring, clears the staged packet,
// and sets the change sequence to 0 and the next id to 1. It needs no
// clearing pass.
`include "dedup_inbox_with_tombstones_macros.svh"
module dedup_inbox_with_tombstones #(
  parameter int unsigned INBOX_DEPTH = dib_pkg::INBOX_DEPTH_DEF,
  parameter int unsigned TEXT_LIMIT  = dib_pkg::TEXT_LIMIT_DEF,
  parameter int unsigned TOMB_DEPTH  = dib_pkg::TOMB_DEPTH_DEF
) (
  input logic          clk,
  input logic          rst,
  dib_stream_if.sink   req,
  dib_stream_if.source rsp
);
  import dib_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic rsp_ins;
  logic rsp_rej;
  logic req_cmd;

  assign rsp_ins = rsp.valid && ((rsp.data.outcome == OUT_INSERTED) ||
                                 (rsp.data.outcome == OUT_INS_EVICT));
  assign rsp_rej = rsp.valid && (rsp.data.outcome == OUT_REJECTED);
  assign req_cmd = req.valid && req.ready && (req.data.op != OP_BYTE);

  dib_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.data.op),
    .req_last  (req.data.last_byte),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dib_datapath #(
    .INBOX_DEPTH (INBOX_DEPTH),
    .TEXT_LIMIT  (TEXT_LIMIT),
    .TOMB_DEPTH  (TOMB_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (req.data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (rsp.data)
  );

  `DIB_ASSERT_IMP(a_ins_id, clk, rst, rsp_ins, rsp.data.entry_id != 32'd0)
  `DIB_ASSERT_IMP(a_rej_flag, clk, rst, rsp_rej, !rsp.data.accepted)
  `DIB_ASSERT_NEXT(a_busy, clk, rst, req_cmd, !req.ready)

endmodule
